// File: rtl/pwts_pkg.sv
// Shared types, widths and helpers for the perspective world-to-screen pipeline.
package pwts_pkg;

  localparam int CW    = 50;  // clip coordinate width, signed Q34.16 range
  localparam int PW    = 67;  // mapping product width
  localparam int NW    = 68;  // numerator width
  localparam int DW    = 51;  // denominator width
  localparam int QW    = 16;  // quotient bits
  localparam int NSTEP = 16;  // divider steps
  localparam int NREG  = 8;
  localparam int AW    = 6;   // APB address width

  localparam logic signed [CW-1:0] W_MIN = CW'(656);

  typedef enum logic {
    MODE_ROW_MAJOR = 1'b0,
    MODE_COL_MAJOR = 1'b1
  } mode_e;

  typedef logic [NREG-1:0][63:0] coef_bank_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [13:0]        win_width;
    logic [13:0]        win_height;
  } point_t;

  typedef struct packed {
    logic               mode;
    logic [13:0]        win_width;
    logic [13:0]        win_height;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cw;
    logic               visible;
  } clip_t;

  typedef struct packed {
    logic          visible;
    logic [1:0]    neg;
    logic [NW-1:0] mag_x;
    logic [NW-1:0] mag_y;
    logic [DW-1:0] den;
  } frac_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } screen_t;

  // Matrix entry idx: register idx/2, low half for even entries.
  function automatic logic signed [31:0] coef_at(coef_bank_t bank, logic [3:0] idx);
    logic [63:0] pair;
    pair = bank[idx[3:1]];
    return idx[0] ? pair[63:32] : pair[31:0];
  endfunction

endpackage

// File: rtl/pwts_pt_if.sv
// Input channel carrying one world point per transaction.
interface pwts_pt_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [13:0]        win_width;
  logic [13:0]        win_height;

  modport source(output valid, mode, pos_x, pos_y, pos_z, win_width, win_height,
                 input ready);
  modport sink(input valid, mode, pos_x, pos_y, pos_z, win_width, win_height,
               output ready);
endinterface

// File: rtl/pwts_scr_if.sv
// Output channel carrying one screen result per transaction.
interface pwts_scr_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;

  modport source(output valid, visible, screen_x, screen_y, input ready);
  modport sink(input valid, visible, screen_x, screen_y, output ready);
endinterface

// File: rtl/pwts_xform.sv
// Matrix transform: coefficient select, nine products, clip row sums.
module pwts_xform (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pwts_pkg::coef_bank_t   coefs_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pwts_pkg::point_t       in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pwts_pkg::clip_t        out_data_o
);

  // Stage A: selected coefficients.
  logic                 a_v_q;
  pwts_pkg::point_t     a_pt_q;
  logic signed [31:0]   a_cm_q [3][3];
  logic signed [31:0]   a_ct_q [3];
  logic signed [31:0]   a_cm_d [3][3];
  logic signed [31:0]   a_ct_d [3];
  // Stage B: products.
  logic                 b_v_q;
  logic                 b_mode_q;
  logic [13:0]          b_w_q, b_h_q;
  logic signed [63:0]   b_prod_q [3][3];
  logic signed [31:0]   b_ct_q [3];
  logic signed [31:0]   b_pos [3];
  // Stage C: clip sums.
  logic                 c_v_q;
  pwts_pkg::clip_t      c_q, c_d;
  logic signed [pwts_pkg::CW-1:0] acc [3];

  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c      = !c_v_q || out_ready_i;
  assign rdy_b      = !b_v_q || rdy_c;
  assign rdy_a      = !a_v_q || rdy_b;
  assign in_ready_o = rdy_a;

  // Clip rows x, y and w are matrix rows 0, 1 and 3.
  always_comb begin
    logic [3:0] row;
    for (int r = 0; r < 3; r++) begin
      row = (r == 2) ? 4'd3 : 4'(r);
      for (int c = 0; c < 3; c++) begin
        if (in_data_i.mode == pwts_pkg::MODE_COL_MAJOR) begin
          a_cm_d[r][c] = pwts_pkg::coef_at(coefs_i, 4'(c * 4) + row);
        end else begin
          a_cm_d[r][c] = pwts_pkg::coef_at(coefs_i, {row[1:0], 2'b00} + 4'(c));
        end
      end
      if (in_data_i.mode == pwts_pkg::MODE_COL_MAJOR) begin
        a_ct_d[r] = pwts_pkg::coef_at(coefs_i, 4'd12 + row);
      end else begin
        a_ct_d[r] = pwts_pkg::coef_at(coefs_i, {row[1:0], 2'b11});
      end
    end
  end

  assign b_pos[0] = a_pt_q.pos_x;
  assign b_pos[1] = a_pt_q.pos_y;
  assign b_pos[2] = a_pt_q.pos_z;

  // Products are floored to 16 fraction bits (Q34.16) before summing.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = pwts_pkg::CW'(b_ct_q[r]);
      for (int c = 0; c < 3; c++) begin
        acc[r] = acc[r] + pwts_pkg::CW'(b_prod_q[r][c] >>> 16);
      end
    end
    c_d.mode       = b_mode_q;
    c_d.win_width  = b_w_q;
    c_d.win_height = b_h_q;
    c_d.cx         = acc[0];
    c_d.cy         = acc[1];
    c_d.cw         = acc[2];
    c_d.visible    = (acc[2] >= pwts_pkg::W_MIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (rdy_a) a_v_q <= in_valid_i;
      if (rdy_b) b_v_q <= a_v_q;
      if (rdy_c) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_pt_q <= in_data_i;
      a_cm_q <= a_cm_d;
      a_ct_q <= a_ct_d;
    end
    if (rdy_b) begin
      b_mode_q <= a_pt_q.mode;
      b_w_q    <= a_pt_q.win_width;
      b_h_q    <= a_pt_q.win_height;
      b_ct_q   <= a_ct_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          b_prod_q[r][c] <= b_pos[c] * a_cm_q[r][c];
        end
      end
    end
    if (rdy_c) c_q <= c_d;
  end

  assign out_valid_o = c_v_q;
  assign out_data_o  = c_q;

endmodule

// File: rtl/pwts_map.sv
// Viewport mapping: builds signed numerators and the common denominator.
module pwts_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pwts_pkg::clip_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pwts_pkg::frac_t   out_data_o
);

  localparam int PW = pwts_pkg::PW;
  localparam int NW = pwts_pkg::NW;
  localparam int DW = pwts_pkg::DW;
  localparam int CW = pwts_pkg::CW;

  logic                 d_v_q;
  logic                 d_vis_q;
  logic signed [PW-1:0] d_ax_q, d_bx_q, d_ay_q, d_by_q;
  logic signed [PW-1:0] d_ax_d, d_bx_d, d_ay_d, d_by_d;
  logic [DW-1:0]        d_den_q, d_den_d;
  logic                 e_v_q;
  pwts_pkg::frac_t      e_q, e_d;

  logic rdy_d, rdy_e;
  assign rdy_e      = !e_v_q || out_ready_i;
  assign rdy_d      = !d_v_q || rdy_e;
  assign in_ready_o = rdy_d;

  // Mode 0: W*(w+x) over 2w. Mode 1: (hw+1)*x + hw*w over w, y with 1-hh.
  always_comb begin
    logic signed [15:0]   opx, opy, hw_s, hh_s;
    logic signed [CW:0]   bx, by, cw_e;
    hw_s = signed'({3'b000, in_data_i.win_width[13:1]});
    hh_s = signed'({3'b000, in_data_i.win_height[13:1]});
    cw_e = (CW+1)'(in_data_i.cw);
    if (in_data_i.mode == pwts_pkg::MODE_COL_MAJOR) begin
      opx     = hw_s + 16'sd1;
      opy     = 16'sd1 - hh_s;
      bx      = (CW+1)'(in_data_i.cx);
      by      = (CW+1)'(in_data_i.cy);
      d_bx_d  = hw_s * cw_e;
      d_by_d  = hh_s * cw_e;
      d_den_d = DW'(in_data_i.cw);
    end else begin
      opx     = signed'({2'b00, in_data_i.win_width});
      opy     = signed'({2'b00, in_data_i.win_height});
      bx      = cw_e + (CW+1)'(in_data_i.cx);
      by      = cw_e - (CW+1)'(in_data_i.cy);
      d_bx_d  = '0;
      d_by_d  = '0;
      d_den_d = {in_data_i.cw[DW-2:0], 1'b0};
    end
    d_ax_d = opx * bx;
    d_ay_d = opy * by;
  end

  always_comb begin
    logic signed [NW-1:0] nx, ny;
    nx = NW'(d_ax_q) + NW'(d_bx_q);
    ny = NW'(d_ay_q) + NW'(d_by_q);
    e_d.visible = d_vis_q;
    e_d.neg     = {ny[NW-1], nx[NW-1]};
    e_d.mag_x   = nx[NW-1] ? NW'(-nx) : NW'(nx);
    e_d.mag_y   = ny[NW-1] ? NW'(-ny) : NW'(ny);
    e_d.den     = d_den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (rdy_d) d_v_q <= in_valid_i;
      if (rdy_e) e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      d_vis_q <= in_data_i.visible;
      d_ax_q  <= d_ax_d;
      d_bx_q  <= d_bx_d;
      d_ay_q  <= d_ay_d;
      d_by_q  <= d_by_d;
      d_den_q <= d_den_d;
    end
    if (rdy_e) e_q <= e_d;
  end

  assign out_valid_o = e_v_q;
  assign out_data_o  = e_q;

endmodule

// File: rtl/pwts_div.sv
// Two-lane pipelined restoring divider with overflow detect and 16-bit saturation.
module pwts_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pwts_pkg::frac_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pwts_pkg::screen_t out_data_o
);

  localparam int NW = pwts_pkg::NW;
  localparam int DW = pwts_pkg::DW;
  localparam int QW = pwts_pkg::QW;
  localparam int NS = pwts_pkg::NSTEP;

  // Stage 0 checks for quotient overflow; stages 1..NS each retire one bit.
  logic                v_q   [NS+1];
  logic                vis_q [NS+1];
  logic [DW-1:0]       den_q [NS+1];
  logic [1:0]          neg_q [NS+1];
  logic [1:0]          ovf_q [NS+1];
  logic [NW-1:0]       rem_q [NS+1][2];
  logic [QW-1:0]       quo_q [NS+1][2];
  logic [NS+1:0]       rdy;
  logic [NW-1:0]       trial [1:NS];
  logic [1:0]          take  [1:NS];

  logic                o_v_q;
  pwts_pkg::screen_t   o_q, o_d;

  assign rdy[NS+1]  = !o_v_q || out_ready_i;
  assign in_ready_o = rdy[0];

  genvar s;
  for (s = 0; s <= NS; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) v_q[k] <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
      if (rdy[NS+1]) o_v_q <= v_q[NS];
    end
  end

  // Stage k compares against the divisor shifted to quotient bit NS-k.
  always_comb begin
    for (int k = 1; k <= NS; k++) begin
      trial[k] = NW'(den_q[k-1]) << (NS - k);
      for (int l = 0; l < 2; l++) begin
        take[k][l] = rem_q[k-1][l] >= trial[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      vis_q[0]    <= in_data_i.visible;
      den_q[0]    <= in_data_i.den;
      neg_q[0]    <= in_data_i.neg;
      ovf_q[0]    <= {in_data_i.mag_y >= NW'({in_data_i.den, {QW{1'b0}}}),
                      in_data_i.mag_x >= NW'({in_data_i.den, {QW{1'b0}}})};
      rem_q[0][0] <= in_data_i.mag_x;
      rem_q[0][1] <= in_data_i.mag_y;
      quo_q[0][0] <= '0;
      quo_q[0][1] <= '0;
    end
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k]) begin
        vis_q[k] <= vis_q[k-1];
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        for (int l = 0; l < 2; l++) begin
          rem_q[k][l] <= take[k][l] ? rem_q[k-1][l] - trial[k] : rem_q[k-1][l];
          quo_q[k][l] <= quo_q[k-1][l] | (QW'(take[k][l]) << (NS - k));
        end
      end
    end
  end

  function automatic logic signed [15:0] sat(logic neg, logic ovf, logic [QW-1:0] q);
    logic signed [15:0] r;
    if (!neg) begin
      r = (ovf || q[QW-1]) ? 16'sh7fff : signed'(q);
    end else if (ovf || (q > 16'h8000)) begin
      r = 16'sh8000;
    end else begin
      r = signed'(16'(-q));
    end
    return r;
  endfunction

  always_comb begin
    o_d.visible  = vis_q[NS];
    o_d.screen_x = vis_q[NS] ? sat(neg_q[NS][0], ovf_q[NS][0], quo_q[NS][0]) : '0;
    o_d.screen_y = vis_q[NS] ? sat(neg_q[NS][1], ovf_q[NS][1], quo_q[NS][1]) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS+1]) o_q <= o_d;
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

  // A hidden point leaves the divider with both coordinates cleared.
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && !o_q.visible |-> o_q.screen_x == '0 && o_q.screen_y == '0)
    else $error("hidden point with nonzero screen coordinates");

  // Without overflow the final x remainder is below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS] && vis_q[NS] && !ovf_q[NS][0] |-> rem_q[NS][0] < NW'(den_q[NS]))
    else $error("divider remainder out of range");

  // A non-negative x numerator never yields a negative screen x value.
  a_sign_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS] && rdy[NS+1] && !neg_q[NS][0] |=> !o_q.screen_x[15])
    else $error("sign of screen x flipped");

endmodule

// File: rtl/perspective_world_to_screen_top.sv
// Top level: coefficient registers, APB port and the projection pipeline.
//
// Each point runs through a 23-stage pipeline: three stages for coefficient
// select, the nine 32x32 products and the clip sums, two stages for the viewport
// products and numerator forming, one overflow-check stage, sixteen one-bit
// stages of the restoring divider (one per quotient bit, x and y lanes side by
// side) and an output register that saturates. A new point is taken every cycle
// while the output is not held. Every stage holds its own valid bit, so bubbles
// close up and input keeps flowing while a result waits at the output until every
// stage is full. The eight 64-bit coefficient registers sit at byte addresses 8*i
// and must be written while no point is in flight.
module perspective_world_to_screen_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pwts_pt_if.sink                   pt_i,
  pwts_scr_if.source                scr_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pwts_pkg::AW-1:0]   paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  pwts_pkg::coef_bank_t coef_q;
  pwts_pkg::point_t     pt;
  pwts_pkg::clip_t      clip;
  pwts_pkg::frac_t      frac;
  pwts_pkg::screen_t    res;
  logic                 clip_v, clip_r, frac_v, frac_r;

  assign pready = 1'b1;
  assign prdata = coef_q[paddr[5:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      coef_q[paddr[5:3]] <= pwdata;
    end
  end

  assign pt.mode       = pt_i.mode;
  assign pt.pos_x      = pt_i.pos_x;
  assign pt.pos_y      = pt_i.pos_y;
  assign pt.pos_z      = pt_i.pos_z;
  assign pt.win_width  = pt_i.win_width;
  assign pt.win_height = pt_i.win_height;

  pwts_xform u_xform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coefs_i    (coef_q),
    .in_valid_i (pt_i.valid),
    .in_ready_o (pt_i.ready),
    .in_data_i  (pt),
    .out_valid_o(clip_v),
    .out_ready_i(clip_r),
    .out_data_o (clip)
  );

  pwts_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (clip_v),
    .in_ready_o (clip_r),
    .in_data_i  (clip),
    .out_valid_o(frac_v),
    .out_ready_i(frac_r),
    .out_data_o (frac)
  );

  pwts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frac_v),
    .in_ready_o (frac_r),
    .in_data_i  (frac),
    .out_valid_o(scr_o.valid),
    .out_ready_i(scr_o.ready),
    .out_data_o (res)
  );

  assign scr_o.visible  = res.visible;
  assign scr_o.screen_x = res.screen_x;
  assign scr_o.screen_y = res.screen_y;

endmodule

// File: tb/tb_perspective_world_to_screen_top.sv
// Self-checking testbench for the perspective world-to-screen projection pipeline.
module tb_perspective_world_to_screen_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_POINTS = 145;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [pwts_pkg::AW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  pwts_pt_if pt();
  pwts_scr_if scr();

  perspective_world_to_screen_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pt_i(pt), .scr_o(scr),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [63:0] coef_regs[pwts_pkg::NREG];
  pwts_pkg::point_t pending_points[$];
  pwts_pkg::screen_t expected_screens[$];
  pwts_pkg::point_t cur_point;
  bit reset_done;
  bit calm;
  bit rx_hold;
  int tx_gap;
  int rx_wait;
  int error_count;
  int cycle_count;
  int accepted_points;

  always #10 clk_i = ~clk_i;

  function automatic logic signed [127:0] clip_row(int row, logic colmaj,
                                                   pwts_pkg::point_t p);
    logic signed [63:0] pos[3];
    logic signed [63:0] c, prod;
    logic signed [127:0] acc;
    logic [63:0] pair;
    int idx;
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      idx = colmaj ? (k * 4 + row) : (row * 4 + k);
      pair = coef_regs[idx / 2];
      c = $signed(idx % 2 ? pair[63:32] : pair[31:0]);
      if (k < 3) begin
        prod = pos[k] * c;
        acc = acc + (prod >>> 16);
      end else begin
        // Translation term is added as it stands.
        acc = acc + c;
      end
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] clamp16(logic signed [127:0] v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic pwts_pkg::screen_t project_point(pwts_pkg::point_t p);
    logic signed [127:0] cx, cy, cw, ww, wh, hw, hh, sx, sy;
    pwts_pkg::screen_t r;
    cx = clip_row(0, p.mode, p);
    cy = clip_row(1, p.mode, p);
    cw = clip_row(3, p.mode, p);
    ww = p.win_width;
    wh = p.win_height;
    r = '0;
    if (cw < 656) return r;
    if (p.mode == pwts_pkg::MODE_ROW_MAJOR) begin
      sx = (ww * (cw + cx)) / (2 * cw);
      sy = (wh * (cw - cy)) / (2 * cw);
    end else begin
      hw = ww / 2;
      hh = wh / 2;
      sx = ((hw + 1) * cx + hw * cw) / cw;
      sy = ((1 - hh) * cy + hh * cw) / cw;
    end
    r.visible = 1'b1;
    r.screen_x = clamp16(sx);
    r.screen_y = clamp16(sy);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at cycle %0d", field, got, want,
             cycle_count);
    error_count++;
  endtask

  // Point driver: offers queued points with random gaps.
  always @(posedge clk_i) begin
    logic next_valid;
    next_valid = pt.valid;
    if (pt.valid && pt.ready) begin
      expected_screens.push_back(project_point(cur_point));
      accepted_points++;
      next_valid = 1'b0;
      tx_gap = calm ? 0 : $urandom_range(0, 17);
    end
    if (!next_valid && reset_done) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_points.size() > 0) begin
        cur_point = pending_points.pop_front();
        pt.mode <= cur_point.mode;
        pt.pos_x <= cur_point.pos_x;
        pt.pos_y <= cur_point.pos_y;
        pt.pos_z <= cur_point.pos_z;
        pt.win_width <= cur_point.win_width;
        pt.win_height <= cur_point.win_height;
        next_valid = 1'b1;
      end
    end
    pt.valid <= next_valid;
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin
    pwts_pkg::screen_t want;
    if (scr.valid && scr.ready) begin
      if (expected_screens.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_screens.pop_front();
        if (scr.visible !== want.visible)
          report_mismatch("visible", scr.visible, want.visible);
        if (scr.screen_x !== want.screen_x)
          report_mismatch("screen_x", scr.screen_x, want.screen_x);
        if (scr.screen_y !== want.screen_y)
          report_mismatch("screen_y", scr.screen_y, want.screen_y);
      end
      rx_wait = calm ? 0 : $urandom_range(0, 17);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    scr.ready <= reset_done && !rx_hold && rx_wait == 0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One long receiver hold-off so the pipeline fills and stalls its input.
  initial begin
    wait (accepted_points >= 400);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic apb_write(int idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pwts_pkg::AW'(idx * 8);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    coef_regs[idx] = value;
  endtask

  task automatic wait_idle();
    while (pending_points.size() > 0 || pt.valid || expected_screens.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_coef();
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  // Loads one matrix; kinds: projection-like, random, max, min, all ones, zero.
  task automatic load_matrix(int kind);
    logic [31:0] e[16];
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: begin
          e[i] = small_coef();
        end
        1: begin
          e[i] = $urandom;
        end
        2: begin
          e[i] = 32'h7FFF_FFFF;
        end
        3: begin
          e[i] = 32'h8000_0000;
        end
        4: begin
          e[i] = 32'hFFFF_FFFF;
        end
        default: begin
          e[i] = '0;
        end
      endcase
    end
    if (kind == 0) begin
      // Keep clip w mostly positive in both orders.
      foreach (e[i])
        if (i == 3 || i == 7 || i == 11 || i == 12 || i == 13 || i == 14)
          e[i] = $urandom_range(0, 1 << 17);
      e[15] = $urandom_range(32'h1_0000, 32'h40_0000);
    end
    for (int k = 0; k < pwts_pkg::NREG; k++) apb_write(k, {e[2 * k + 1], e[2 * k]});
  endtask

  function automatic pwts_pkg::point_t rand_point(bit near);
    pwts_pkg::point_t p;
    p.mode = 1'($urandom_range(0, 1));
    if (near) begin
      p.pos_x = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      p.pos_y = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      p.pos_z = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    end else begin
      p.pos_x = $urandom;
      p.pos_y = $urandom;
      p.pos_z = $urandom;
    end
    p.win_width = 14'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom);
    p.win_height = 14'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom);
    return p;
  endfunction

  function automatic pwts_pkg::point_t make_point(logic m, logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [13:0] w,
                                                  logic [13:0] h);
    pwts_pkg::point_t p;
    p.mode = m;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    p.win_width = w;
    p.win_height = h;
    return p;
  endfunction

  initial begin
    int kinds[9];
    kinds = '{0, 1, 0, 2, 0, 3, 4, 5, 0};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pt.valid = 1'b0;
    pt.mode = 1'b0;
    pt.pos_x = '0;
    pt.pos_y = '0;
    pt.pos_z = '0;
    pt.win_width = '0;
    pt.win_height = '0;
    scr.ready = 1'b0;
    foreach (coef_regs[i]) coef_regs[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reset_done <= 1'b1;

    // cx = x (+ y in column order), cy = x in row order, cw = z in both orders.
    apb_write(0, 64'h0000_0000_0001_0000);
    apb_write(2, 64'h0000_0000_0001_0000);
    apb_write(5, 64'h0001_0000_0000_0000);
    apb_write(7, 64'h0000_0000_0001_0000);
    for (int m = 0; m < 2; m++) begin
      pending_points.push_back(make_point(1'(m), 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h7FFF_FFFF, 14'h3FFF, 14'h3FFF));
      pending_points.push_back(make_point(1'(m), 32'h8000_0000, 32'h7FFF_FFFF, 32'd656,
                                          14'h3FFF, 14'h3FFF));
      pending_points.push_back(make_point(1'(m), 32'h1_0000, 32'h1_0000, 32'd655,
                                          14'd640, 14'd480));
      pending_points.push_back(make_point(1'(m), 32'h0, 32'h0, 32'h0, 14'd640, 14'd480));
      pending_points.push_back(make_point(1'(m), 32'h1_0000, 32'h2_0000, 32'hFFFF_0000,
                                          14'd640, 14'd480));
      pending_points.push_back(make_point(1'(m), 32'h0, 32'h0, 32'h1_0000, 14'd0, 14'd0));
      pending_points.push_back(make_point(1'(m), 32'h8000, 32'hFFFF_8000, 32'h1_0000,
                                          14'd1921, 14'd1081));
      pending_points.push_back(make_point(1'(m), 32'h0, 32'h0, 32'h7FFF_FFFF, 14'h3FFF,
                                          14'd1));
      pending_points.push_back(make_point(1'(m), 32'hFFFF_FFFF, 32'h1, 32'd657, 14'd1,
                                          14'h3FFF));
      pending_points.push_back(make_point(1'(m), 32'h40_0000, 32'hFFC0_0000, 32'h2_0000,
                                          14'd800, 14'd600));
    end
    wait_idle();

    foreach (kinds[ph]) begin
      load_matrix(kinds[ph]);
      calm = (ph % 3 == 2);
      for (int n = 0; n < PHASE_POINTS; n++)
        pending_points.push_back(rand_point($urandom_range(0, 9) < 7));
      wait_idle();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
